[rtl/skbt_pkg.sv]
// Shared types, codes and constants of the sorted key bucket table.
`default_nettype none
package skbt_pkg;

	// Default number of entries in the bucket.
	localparam int DEPTH_DEF = 16;

	// Fixed field widths.
	localparam int FUNC_W   = 2;
	localparam int KEY_W    = 64;
	localparam int HANDLE_W = 64;

	// Operation codes carried in the func field.
	typedef logic [FUNC_W-1:0] func_t;
	localparam func_t FUNC_PUSH = 2'd0;
	localparam func_t FUNC_PEEK = 2'd1;
	localparam func_t FUNC_POP  = 2'd2;
	localparam func_t FUNC_SET  = 2'd3;

	// One stored entry: key and item handle side by side in one memory word.
	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT_UP,
		ST_INS_WR,
		ST_SHIFT_DN,
		ST_SET_WR,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic search_en;
		logic up_start;
		logic up_en;
		logic ins_wr;
		logic dn_start;
		logic dn_en;
		logic set_wr;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic srch_done;
		logic do_ins;
		logic do_del;
		logic do_set;
		logic up_done;
		logic dn_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[rtl/skbt_in_if.sv]
// Request channel: one operation word with valid and ready.
`default_nettype none
interface skbt_in_if;
	import skbt_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [KEY_W-1:0]    key;
	logic [HANDLE_W-1:0] item_handle;

	modport source (output valid, output func, output key, output item_handle, input ready);
	modport sink   (input valid, input func, input key, input item_handle, output ready);
endinterface
`default_nettype wire

[rtl/skbt_out_if.sv]
// Response channel: one result word with valid and ready.
`default_nettype none
interface skbt_out_if #(
	parameter int CNT_W = 5
);
	import skbt_pkg::*;

	logic                valid;
	logic                ready;
	logic                found;
	logic [HANDLE_W-1:0] old_handle;
	logic                rejected_full;
	logic [CNT_W-1:0]    entry_count;

	modport source (output valid, output found, output old_handle, output rejected_full,
		output entry_count, input ready);
	modport sink   (input valid, input found, input old_handle, input rejected_full,
		input entry_count, output ready);
endinterface
`default_nettype wire

[rtl/skbt_ctrl.sv]
// Controller state machine that sequences search, shift and write phases.
`default_nettype none
module skbt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire skbt_pkg::sts_t sts,
	output skbt_pkg::cmd_t      cmd
);
	import skbt_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (sts.srch_done) begin
					priority if (sts.do_del) state_nxt = ST_SHIFT_DN;
					else if (sts.do_set)     state_nxt = ST_SET_WR;
					else if (sts.do_ins)     state_nxt = ST_SHIFT_UP;
					else                     state_nxt = ST_FINISH;
				end
			end
			ST_SHIFT_UP: begin
				if (sts.up_done) state_nxt = ST_INS_WR;
			end
			ST_INS_WR: begin
				state_nxt = ST_FINISH;
			end
			ST_SHIFT_DN: begin
				if (sts.dn_done) state_nxt = ST_FINISH;
			end
			ST_SET_WR: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_SEARCH: begin
				cmd.search_en = 1'b1;
				cmd.dn_start  = sts.srch_done && sts.do_del;
				cmd.up_start  = sts.srch_done && !sts.do_del && !sts.do_set && sts.do_ins;
			end
			ST_SHIFT_UP: begin
				cmd.up_en = 1'b1;
			end
			ST_INS_WR: begin
				cmd.ins_wr = 1'b1;
			end
			ST_SHIFT_DN: begin
				cmd.dn_en = 1'b1;
			end
			ST_SET_WR: begin
				cmd.set_wr = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// A loaded word always starts with the search phase.
	a_load_to_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_SEARCH)
		else $error("accepted word did not enter the search phase");

	// Shift phases are only entered through their start commands.
	a_up_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_SHIFT_UP) |-> $past(cmd.up_start))
		else $error("shift up entered without start");

	a_dn_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_SHIFT_DN) |-> $past(cmd.dn_start))
		else $error("shift down entered without start");

endmodule
`default_nettype wire

[rtl/skbt_dp.sv]
// Datapath: entry memory, search compare, shift counters and result register.
`default_nettype none
module skbt_dp #(
	parameter int DEPTH = skbt_pkg::DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire skbt_pkg::cmd_t                cmd,
	output skbt_pkg::sts_t                     sts,
	input  wire logic [skbt_pkg::FUNC_W-1:0]   req_func,
	input  wire logic [skbt_pkg::KEY_W-1:0]    req_key,
	input  wire logic [skbt_pkg::HANDLE_W-1:0] req_handle,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output logic                               rsp_found,
	output logic [skbt_pkg::HANDLE_W-1:0]      rsp_old_handle,
	output logic                               rsp_rejected_full,
	output logic [CW-1:0]                      rsp_entry_count
);
	import skbt_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Entry memory and its registered read port.
	entry_t mem_q [DEPTH];
	entry_t rd_ent_s1;
	logic   rd_pend_s1;
	logic [CW-1:0] rd_idx_s1;

	// Current operation.
	func_t               op_q;
	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;

	// Table and walk state.
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_addr_q;
	logic          act_q;
	logic [CW-1:0] pos_q;

	// Result being built and the output register.
	logic                found_q;
	logic [HANDLE_W-1:0] old_q;
	logic                rej_q;
	logic                out_vld_q;
	logic                out_found_q;
	logic [HANDLE_W-1:0] out_old_q;
	logic                out_rej_q;
	logic [CW-1:0]       out_cnt_q;

	logic          full;
	logic          ge;
	logic          last;
	logic          srch_done;
	logic          srch_hit;
	logic          rep_hit;
	logic [CW-1:0] srch_pos;
	logic          ins_need;
	logic          rd_en;
	logic          wr_en;
	logic [CW-1:0] wr_idx;
	entry_t        wr_ent;

	// Search compare on the word just read.
	always_comb begin
		full      = (cnt_q == CW'(DEPTH));
		ge        = rd_ent_s1.key >= key_q;
		last      = (CW'(rd_idx_s1 + 1'b1) == cnt_q);
		srch_done = (cnt_q == '0) || (rd_pend_s1 && (ge || last));
		srch_hit  = rd_pend_s1 && ge && (rd_ent_s1.key == key_q);
		srch_pos  = (rd_pend_s1 && ge) ? rd_idx_s1 : cnt_q;
		ins_need  = (op_q == FUNC_PUSH) || ((op_q == FUNC_SET) && !srch_hit);
		// A push always reports no match, even when the key is already stored.
		rep_hit   = srch_hit && (op_q != FUNC_PUSH);
	end

	// Status back to the controller.
	always_comb begin
		sts.srch_done = srch_done;
		sts.do_ins    = ins_need && !full;
		sts.do_del    = (op_q == FUNC_POP) && srch_hit;
		sts.do_set    = (op_q == FUNC_SET) && srch_hit;
		sts.up_done   = !act_q && !rd_pend_s1;
		sts.dn_done   = !act_q && !rd_pend_s1;
		sts.out_free  = !out_vld_q || rsp_ready;
	end

	// Read issue: ascending during search and remove, descending during insert.
	always_comb begin
		rd_en = (cmd.search_en && !srch_done && (rd_addr_q < cnt_q))
			|| ((cmd.up_en || cmd.dn_en) && act_q);
	end

	// Write port: moved entries during shifts, the new entry otherwise.
	always_comb begin
		wr_en  = 1'b0;
		wr_idx = '0;
		wr_ent = rd_ent_s1;
		if (cmd.up_en && rd_pend_s1) begin
			wr_en  = 1'b1;
			wr_idx = CW'(rd_idx_s1 + 1'b1);
		end
		if (cmd.dn_en && rd_pend_s1) begin
			wr_en  = 1'b1;
			wr_idx = CW'(rd_idx_s1 - 1'b1);
		end
		if (cmd.ins_wr || cmd.set_wr) begin
			wr_en      = 1'b1;
			wr_idx     = pos_q;
			wr_ent.key    = key_q;
			wr_ent.handle = handle_q;
		end
	end

	// Memory and read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx[IW-1:0]] <= wr_ent;
		end
		if (rd_en) begin
			rd_ent_s1 <= mem_q[rd_addr_q[IW-1:0]];
		end
	end

	// Captured operation and result payload.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr_q;
		if (cmd.load) begin
			op_q     <= req_func;
			key_q    <= req_key;
			handle_q <= req_handle;
		end
		if (cmd.search_en && srch_done) begin
			pos_q   <= srch_pos;
			found_q <= rep_hit;
			old_q   <= rep_hit ? rd_ent_s1.handle : '0;
			rej_q   <= ins_need && full;
		end
		if (cmd.finish) begin
			out_found_q <= found_q;
			out_old_q   <= old_q;
			out_rej_q   <= rej_q;
			out_cnt_q   <= cnt_q;
		end
	end

	// Walk control, entry count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			rd_addr_q  <= '0;
			act_q      <= 1'b0;
			rd_pend_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_en;
			if (cmd.load) begin
				rd_addr_q <= '0;
			end
			if (cmd.search_en && rd_en) begin
				rd_addr_q <= CW'(rd_addr_q + 1'b1);
			end
			if (cmd.up_start) begin
				rd_addr_q <= CW'(cnt_q - 1'b1);
				act_q     <= srch_pos < cnt_q;
			end
			if (cmd.dn_start) begin
				rd_addr_q <= CW'(srch_pos + 1'b1);
				act_q     <= CW'(srch_pos + 1'b1) < cnt_q;
			end
			if (cmd.up_en && act_q) begin
				rd_addr_q <= CW'(rd_addr_q - 1'b1);
				if (rd_addr_q == pos_q) act_q <= 1'b0;
			end
			if (cmd.dn_en && act_q) begin
				rd_addr_q <= CW'(rd_addr_q + 1'b1);
				if (CW'(rd_addr_q + 1'b1) == cnt_q) act_q <= 1'b0;
			end
			if (cmd.ins_wr) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end
			if (cmd.dn_en && !act_q && !rd_pend_s1) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
			if (cmd.finish) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid         = out_vld_q;
	assign rsp_found         = out_found_q;
	assign rsp_old_handle    = out_old_q;
	assign rsp_rejected_full = out_rej_q;
	assign rsp_entry_count   = out_cnt_q;

	// The entry count never passes the table size.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above table size");

	// A refused insert is only reported for a full table.
	a_rej_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_rej_q) |-> (out_cnt_q == CW'(DEPTH)))
		else $error("refusal reported for a table that is not full");

	// A word never reports both a hit and a refusal.
	a_found_rej: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_vld_q && out_found_q && out_rej_q))
		else $error("hit and refusal in one word");

	// Writes stay inside the table.
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_idx < CW'(DEPTH)))
		else $error("write outside the table");

	// An insert write grows the table by exactly one.
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |=> (cnt_q == CW'($past(cnt_q) + 1'b1)))
		else $error("insert did not grow the table by one");

endmodule
`default_nettype wire

[rtl/sorted_key_bucket_table_top.sv]
// Top level of the sorted key bucket table: controller plus datapath.
// Each word is searched first, reading entries in ascending key order; a peek, a miss or a
// refusal then goes straight to the result, a remove shifts the entries above the hit down, an
// insert shifts entries up from its position and writes the new entry, and a set hit writes the
// new handle. The result waits while the output is stalled; the next word is taken no earlier
// than the cycle after it is loaded. One entry is read and one written per cycle during a shift.
// Reset: arst_n empties the table and clears the result valid; entry and result contents are not cleared.
`default_nettype none
module sorted_key_bucket_table_top #(
	parameter int DEPTH = skbt_pkg::DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	skbt_in_if.sink    req,
	skbt_out_if.source rsp
);
	import skbt_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	cmd_t cmd;
	sts_t sts;
	logic req_ready;

	// Sequencer.
	skbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table storage and result datapath.
	skbt_dp #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.req_func          (req.func),
		.req_key           (req.key),
		.req_handle        (req.item_handle),
		.rsp_valid         (rsp.valid),
		.rsp_ready         (rsp.ready),
		.rsp_found         (rsp.found),
		.rsp_old_handle    (rsp.old_handle),
		.rsp_rejected_full (rsp.rejected_full),
		.rsp_entry_count   (rsp.entry_count)
	);

	assign req.ready = req_ready;

endmodule
`default_nettype wire

[sim/tb_sorted_key_bucket_table_top.sv]
// Self-checking testbench for the sorted key bucket table top level.
module tb_sorted_key_bucket_table_top;
	timeunit 1ns;
	timeprecision 1ps;
	import skbt_pkg::*;

	localparam int TABLE_DEPTH = DEPTH_DEF;
	localparam int CNT_W       = 5;

	// One request word and one result word as the checker sees them.
	typedef struct packed {
		func_t               func;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} bucket_op_t;

	typedef struct packed {
		logic                found;
		logic [HANDLE_W-1:0] old_handle;
		logic                rejected_full;
		logic [CNT_W-1:0]    entry_count;
	} bucket_res_t;

	// A directed row; a typed result replaces the predicted one when given.
	typedef struct {
		bucket_op_t  op;
		int          reps;
		bit          typed;
		bucket_res_t res;
	} stim_row_t;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] PAT_A    = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [63:0] PAT_5    = 64'h5555_5555_5555_5555;

	logic clk;
	logic arst_n;

	skbt_in_if                   req_if();
	skbt_out_if #(.CNT_W(CNT_W)) rsp_if();

	sorted_key_bucket_table_top #(.DEPTH(TABLE_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Shadow copy of the bucket contents, kept in ascending key order.
	logic [KEY_W-1:0]    shadow_keys    [TABLE_DEPTH];
	logic [HANDLE_W-1:0] shadow_handles [TABLE_DEPTH];
	int unsigned         shadow_count;

	bucket_res_t pending_results[$];
	stim_row_t   stim_rows[$];
	logic [63:0] key_pool[20];
	int          fails;
	bit          calm;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Insert an entry at a position; refused when the bucket is full.
	function automatic bit shadow_insert(input int unsigned pos, input logic [63:0] k,
		input logic [63:0] h);
		if (shadow_count >= TABLE_DEPTH)
			return 1'b0;
		for (int unsigned j = shadow_count; j > pos; j--) begin
			shadow_keys[j]    = shadow_keys[j-1];
			shadow_handles[j] = shadow_handles[j-1];
		end
		shadow_keys[pos]    = k;
		shadow_handles[pos] = h;
		shadow_count++;
		return 1'b1;
	endfunction

	// Apply one operation to the shadow bucket and return the result it gives.
	function automatic bucket_res_t bucket_apply(input bucket_op_t op);
		int unsigned pos;
		bit          hit;
		bucket_res_t r;
		r   = '0;
		pos = 0;
		// The first entry whose key is not below the requested key.
		while (pos < shadow_count && shadow_keys[pos] < op.key)
			pos++;
		hit = (pos < shadow_count) && (shadow_keys[pos] == op.key);
		case (op.func)
			FUNC_PUSH: begin
				if (!shadow_insert(pos, op.key, op.handle))
					r.rejected_full = 1'b1;
			end
			FUNC_PEEK: begin
				if (hit) begin
					r.found      = 1'b1;
					r.old_handle = shadow_handles[pos];
				end
			end
			FUNC_POP: begin
				if (hit) begin
					r.found      = 1'b1;
					r.old_handle = shadow_handles[pos];
					for (int unsigned j = pos; j + 1 < shadow_count; j++) begin
						shadow_keys[j]    = shadow_keys[j+1];
						shadow_handles[j] = shadow_handles[j+1];
					end
					shadow_count--;
				end
			end
			FUNC_SET: begin
				if (hit) begin
					r.found              = 1'b1;
					r.old_handle         = shadow_handles[pos];
					shadow_handles[pos]  = op.handle;
				end else if (!shadow_insert(pos, op.key, op.handle)) begin
					r.rejected_full = 1'b1;
				end
			end
			default: ;
		endcase
		r.entry_count = shadow_count[CNT_W-1:0];
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Keys mostly come from a small pool so that hits and duplicates are common.
	function automatic logic [63:0] pick_key();
		if ($urandom_range(99) < 10)
			return rand64();
		return key_pool[$urandom_range(19)];
	endfunction

	function automatic logic [63:0] pick_handle();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return 64'h0;
		if (r < 15)
			return ALL_ONES;
		return rand64();
	endfunction

	task automatic add_row(input func_t f, input logic [63:0] k, input logic [63:0] h,
		input int reps, input bit typed, input logic fnd, input logic [63:0] old,
		input logic rej, input int cnt);
		stim_row_t row;
		row.op.func              = f;
		row.op.key               = k;
		row.op.handle            = h;
		row.reps                 = reps;
		row.typed                = typed;
		row.res.found            = fnd;
		row.res.old_handle       = old;
		row.res.rejected_full    = rej;
		row.res.entry_count      = cnt[CNT_W-1:0];
		stim_rows.push_back(row);
	endtask

	// Offer one word, wait for it to be taken, then record what it should give.
	task automatic send_word(input bucket_op_t op, input bit typed, input bucket_res_t typed_res);
		bucket_res_t predicted;
		while (!calm && $urandom_range(99) < 34) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.func        <= op.func;
		req_if.key         <= op.key;
		req_if.item_handle <= op.handle;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		predicted = bucket_apply(op);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	// Hold the request side quiet until every outstanding result is back.
	task automatic drain_results();
		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Result side: random back-pressure and comparison against the oldest expectation.
	initial begin
		bucket_res_t got;
		bucket_res_t want;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				got.found         = rsp_if.found;
				got.old_handle    = rsp_if.old_handle;
				got.rejected_full = rsp_if.rejected_full;
				got.entry_count   = rsp_if.entry_count;
				if (pending_results.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected result found=%0b old=%h rej=%0b cnt=%0d",
							$realtime, got.found, got.old_handle, got.rejected_full,
							got.entry_count);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						fails++;
						if (fails <= 10)
							$display({"%0t: mismatch exp found=%0b old=%h rej=%0b cnt=%0d",
								" got found=%0b old=%h rej=%0b cnt=%0d"}, $realtime,
								want.found, want.old_handle, want.rejected_full,
								want.entry_count, got.found, got.old_handle,
								got.rejected_full, got.entry_count);
					end
				end
			end
			rsp_if.ready <= calm || ($urandom_range(99) >= 34);
		end
	end

	// Stimulus: reset, directed table, random traffic, then the verdict.
	initial begin
		bucket_op_t  op;
		bucket_res_t none;
		int unsigned r;
		bit          filling;
		none               = '0;
		fails              = 0;
		calm               = 1'b0;
		shadow_count       = 0;
		arst_n             <= 1'b0;
		req_if.valid       <= 1'b0;
		req_if.func        <= FUNC_PUSH;
		req_if.key         <= '0;
		req_if.item_handle <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty bucket, extreme keys and handles, duplicates, a full bucket.
		add_row(FUNC_PEEK, 64'h0,    64'h0,    1, 1, 0, 64'h0,    0, 0);
		add_row(FUNC_POP,  ALL_ONES, 64'h0,    1, 1, 0, 64'h0,    0, 0);
		add_row(FUNC_SET,  64'h0,    ALL_ONES, 1, 1, 0, 64'h0,    0, 1);
		add_row(FUNC_PUSH, ALL_ONES, 64'h0,    1, 1, 0, 64'h0,    0, 2);
		add_row(FUNC_PUSH, ALL_ONES, 64'h1,    1, 1, 0, 64'h0,    0, 3);
		add_row(FUNC_PEEK, ALL_ONES, 64'h0,    1, 1, 1, 64'h1,    0, 3);
		add_row(FUNC_SET,  ALL_ONES, PAT_A,    1, 1, 1, 64'h1,    0, 3);
		add_row(FUNC_POP,  ALL_ONES, 64'h0,    1, 1, 1, PAT_A,    0, 2);
		add_row(FUNC_PEEK, ALL_ONES, PAT_5,    1, 1, 1, 64'h0,    0, 2);
		add_row(FUNC_POP,  PAT_5,    64'h0,    1, 1, 0, 64'h0,    0, 2);
		add_row(FUNC_PEEK, 64'h0,    64'h0,    1, 1, 1, ALL_ONES, 0, 2);
		add_row(FUNC_PUSH, PAT_5,    PAT_5,   14, 0, 0, 64'h0,    0, 0);
		add_row(FUNC_PUSH, 64'h1,    64'h7,    1, 1, 0, 64'h0,    1, 16);
		add_row(FUNC_SET,  64'h2,    64'h9,    1, 1, 0, 64'h0,    1, 16);
		add_row(FUNC_SET,  64'h0,    64'h3,    1, 1, 1, ALL_ONES, 0, 16);
		add_row(FUNC_PEEK, 64'h0,    64'h0,    1, 1, 1, 64'h3,    0, 16);
		add_row(FUNC_POP,  PAT_5+3,  64'h0,    1, 0, 0, 64'h0,    0, 0);
		add_row(FUNC_PUSH, PAT_A,    PAT_A,    1, 0, 0, 64'h0,    0, 0);
		add_row(FUNC_PEEK, PAT_A,    64'h0,    1, 0, 0, 64'h0,    0, 0);
		add_row(FUNC_POP,  64'h0,    64'h0,    1, 0, 0, 64'h0,    0, 0);

		foreach (stim_rows[i]) begin
			for (int k = 0; k < stim_rows[i].reps; k++) begin
				op        = stim_rows[i].op;
				op.key    = op.key + k;
				op.handle = op.handle + k;
				send_word(op, stim_rows[i].typed, stim_rows[i].res);
			end
		end

		// Random traffic in alternating fill and drain phases.
		filling = 1'b1;
		for (int n = 0; n < 1550; n++) begin
			if (n % 150 == 0) begin
				filling = !filling;
				key_pool[0] = 64'h0;
				key_pool[1] = ALL_ONES;
				key_pool[2] = 64'h1;
				key_pool[3] = ALL_ONES - 1;
				for (int p = 4; p < 20; p++)
					key_pool[p] = rand64();
			end
			calm = (n >= 700 && n < 900);
			if (n == 400)
				drain_results();
			r = $urandom_range(99);
			if (filling)
				op.func = (r < 35) ? FUNC_PUSH : (r < 60) ? FUNC_SET :
					(r < 75) ? FUNC_PEEK : FUNC_POP;
			else
				op.func = (r < 15) ? FUNC_PUSH : (r < 25) ? FUNC_SET :
					(r < 40) ? FUNC_PEEK : FUNC_POP;
			op.key    = pick_key();
			op.handle = pick_handle();
			send_word(op, 1'b0, none);
		end
		calm = 1'b0;

		// Wait out every result and a little longer for anything stray.
		drain_results();
		repeat (TABLE_DEPTH + 10) @(posedge clk);
		if (fails == 0)
			$display("sorted_key_bucket_table_top verification clean");
		else
			$display("sorted_key_bucket_table_top verification failed");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2000000;
		$display("sorted_key_bucket_table_top verification failed");
		$finish;
	end

endmodule
